@@ rtl/dgma_pkg.sv @@
package dgma_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int SAMPLE_W  = 32;
	localparam int DRIFT_W   = 31;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [DRIFT_W-1:0]         drift_t;

	localparam drift_t MAX_DRIFT_RST = drift_t'(10000);

endpackage

@@ rtl/drift_gated_moving_average_top.sv @@
// Channel   Dir  Handshake          Payload (low bit first)
// s_        in   s_tvalid/s_tready  s_tdata: sample_offset[31:0]
// m_        out  m_tvalid/m_tready  m_tdata: average_offset[31:0], fill_count, zero pad
//                                   m_tuser: accepted
// cfg_      in   cfg_wr_en          cfg_wr_data: max_drift[30:0]
//
// One transaction at a time. A rejected sample goes from the update state straight to
// its result; an accepted one waits for the bit-serial divider that forms the rounded
// average. The window lives in one RAM read at the write pointer and written back
// in the update cycle.
// Reset (arst_n, async low) empties the window and clears lock; RAM is not cleared.
// A waiting result does not block the next input transaction; only the final
// hand-off stalls until the output register is free.
module drift_gated_moving_average_top #(
	parameter int DEPTH = dgma_pkg::DEPTH_DEF,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int TDATA_W = ((dgma_pkg::SAMPLE_W + CNT_W + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  dgma_pkg::sample_t      s_tdata,     // sample_offset
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_W-1:0]     m_tdata,     // average_offset, fill_count, pad
	output logic                   m_tuser,     // accepted
	input  logic                   cfg_wr_en,
	input  dgma_pkg::drift_t       cfg_wr_data  // max_drift
);

	import dgma_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W = SAMPLE_W + $clog2(DEPTH);
	localparam int N_W   = SUM_W + 1;
	localparam int D_W   = CNT_W + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_UPD   = 3'd2;
	localparam logic [2:0] ST_MAG   = 3'd3;
	localparam logic [2:0] ST_DIVS  = 3'd4;
	localparam logic [2:0] ST_DIVW  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]              state_q;
	sample_t                 sample_q;
	sample_t                 avg_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0]        mag_q;
	logic                    neg_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [PTR_W-1:0]        ptr_q;
	logic                    locked_q;
	drift_t                  max_drift_q;
	logic                    reject_q;
	logic                    acc_q;
	logic signed [SAMPLE_W:0] delta_q;

	logic                    m_tvalid_q;
	logic [TDATA_W-1:0]      m_tdata_q;
	logic                    m_tuser_q;

	sample_t                 old_sample;
	logic                    full;
	logic signed [SAMPLE_W:0] diff;
	logic [SAMPLE_W:0]       abs_diff;
	logic                    ram_we;
	logic                    div_start;
	logic                    div_done;
	logic [N_W-1:0]          div_quot;
	logic [N_W-1:0]          div_num;
	logic [D_W-1:0]          div_den;
	logic                    out_free;

	assign full     = cnt_q == CNT_W'(DEPTH);
	assign diff     = {sample_q[SAMPLE_W-1], sample_q} - {avg_q[SAMPLE_W-1], avg_q};
	assign abs_diff = diff[SAMPLE_W] ? (SAMPLE_W + 1)'(-diff) : diff;
	assign ram_we   = (state_q == ST_UPD) && !reject_q;
	assign div_start = state_q == ST_DIVS;
	assign div_num  = {mag_q, 1'b0} + N_W'(cnt_q);
	assign div_den  = {cnt_q, 1'b0};
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = state_q == ST_IDLE;

	dgma_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DEPTH)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptr_q),
		.wdata (sample_q),
		.raddr (ptr_q),
		.rdata (old_sample)
	);

	dgma_div #(
		.N_W (N_W),
		.D_W (D_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			ptr_q       <= '0;
			avg_q       <= '0;
			locked_q    <= 1'b0;
			max_drift_q <= MAX_DRIFT_RST;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_drift_q <= cfg_wr_data;
			end
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (reject_q) begin
						state_q <= ST_DONE;
					end else begin
						sum_q <= sum_q + SUM_W'(delta_q);
						if (!full) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (ptr_q == PTR_W'(DEPTH - 1)) begin
							ptr_q <= '0;
						end else begin
							ptr_q <= ptr_q + PTR_W'(1);
						end
						state_q <= ST_MAG;
					end
				end
				ST_MAG: begin
					state_q <= ST_DIVS;
				end
				ST_DIVS: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_done) begin
						avg_q    <= neg_q ? SAMPLE_W'(-div_quot) : div_quot[SAMPLE_W-1:0];
						locked_q <= 1'b1;
						state_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_q <= s_tdata;
		end
		if (state_q == ST_CHECK) begin
			reject_q <= locked_q && (abs_diff > {2'b00, max_drift_q});
			delta_q  <= {sample_q[SAMPLE_W-1], sample_q}
				- (full ? {old_sample[SAMPLE_W-1], old_sample} : '0);
		end
		if (state_q == ST_UPD) begin
			acc_q <= !reject_q;
		end
		if (state_q == ST_MAG) begin
			neg_q <= sum_q[SUM_W-1];
			mag_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : sum_q;
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_tdata_q <= TDATA_W'({cnt_q, avg_q});
			m_tuser_q <= acc_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ rtl/dgma_ram.sv @@
module dgma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/dgma_div.sv @@
// Restoring divider, one quotient bit per cycle.
module dgma_div #(
	parameter int N_W = 37,
	parameter int D_W = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);

	localparam int CW = (N_W > 1) ? $clog2(N_W) : 1;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [N_W-1:0] nq_q;
	logic [D_W-1:0] d_q;
	logic [D_W-1:0] rem_q;
	logic [D_W:0]   trial;
	logic           ge;
	logic           last;

	assign trial = {rem_q, nq_q[N_W-1]};
	assign ge    = trial >= {1'b0, d_q};
	assign last  = cnt_q == CW'(N_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= dividend;
			d_q   <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			nq_q  <= {nq_q[N_W-2:0], ge};
			rem_q <= ge ? D_W'(trial - {1'b0, d_q}) : trial[D_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = nq_q;

endmodule

@@ verif/drift_gated_moving_average_top_tb.sv @@
module drift_gated_moving_average_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dgma_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int TDATA_W     = ((SAMPLE_W + CNT_W + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 143;
	localparam int N_DIR       = 23;

	typedef struct packed {
		logic             accepted;
		sample_t          average;
		logic [CNT_W-1:0] fill;
	} avg_result_t;

	typedef struct {
		bit      is_cfg;
		sample_t smp;
		drift_t  drift;
		bit      known;
		bit      acc;
		sample_t avg;
		int      cnt;
	} dir_row_t;

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               s_tvalid    = 1'b0;
	logic               s_tready;
	sample_t            s_tdata     = '0;     // sample_offset
	logic               m_tvalid;
	logic               m_tready    = 1'b0;
	logic [TDATA_W-1:0] m_tdata;              // average_offset, fill_count, pad
	logic               m_tuser;              // accepted
	logic               cfg_wr_en   = 1'b0;
	drift_t             cfg_wr_data = '0;     // max_drift

	drift_gated_moving_average_top #(.DEPTH(DEPTH)) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// window model
	sample_t     win_mem [DEPTH];
	int          win_fill;
	int          win_ptr;
	longint      win_sum;
	sample_t     cur_avg;
	bit          is_locked;
	drift_t      drift_lim;

	avg_result_t expected_averages [$];
	dir_row_t    dir_rows [N_DIR];

	int          errors;
	int          cycles;
	int          gap_pct;
	int          stall_pct;
	int          hold_reqs;
	int          n_acc;
	int          n_rej;
	int          n_wrap;
	int          n_settings;
	sample_t     avg_lo;
	sample_t     avg_hi;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	// receiver: random stalls plus long hold-offs on request
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		avg_result_t      want;
		sample_t          got_avg;
		logic [CNT_W-1:0] got_cnt;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got_avg = m_tdata[SAMPLE_W-1:0];
				got_cnt = m_tdata[SAMPLE_W +: CNT_W];
				if (m_tuser) n_acc++; else n_rej++;
				if (got_avg < avg_lo) avg_lo = got_avg;
				if (got_avg > avg_hi) avg_hi = got_avg;
				if (expected_averages.size() == 0) begin
					$error("unexpected result: accepted %0d average %0d fill %0d",
						m_tuser, got_avg, got_cnt);
					errors++;
				end else begin
					want = expected_averages.pop_front();
					if (m_tuser !== want.accepted) begin
						$error("accepted: expected %0d, got %0d", want.accepted, m_tuser);
						errors++;
					end
					if (got_avg !== want.average) begin
						$error("average_offset: expected %0d, got %0d", want.average, got_avg);
						errors++;
					end
					if (got_cnt !== want.fill) begin
						$error("fill_count: expected %0d, got %0d", want.fill, got_cnt);
						errors++;
					end
				end
			end
		end
	end

	function automatic avg_result_t update_window_average(input sample_t smp);
		avg_result_t     r;
		longint          diff;
		longint unsigned mag;
		longint unsigned q;
		bit              ok;
		ok = 1'b1;
		if (is_locked) begin
			diff = longint'(smp) - longint'(cur_avg);
			if (diff > longint'(drift_lim) || diff < -longint'(drift_lim))
				ok = 1'b0;
		end
		if (ok) begin
			if (win_fill >= DEPTH) begin
				win_sum -= longint'(win_mem[win_ptr]);
				n_wrap++;
			end else begin
				win_fill++;
			end
			win_mem[win_ptr] = smp;
			win_sum += longint'(smp);
			win_ptr = (win_ptr + 1) % DEPTH;
			mag = (win_sum < 0) ? longint'(-win_sum) : win_sum;
			q = (2 * mag + longint'(win_fill)) / (2 * longint'(win_fill));
			cur_avg = sample_t'((win_sum < 0) ? -longint'(q) : longint'(q));
			is_locked = 1'b1;
		end
		r.accepted = ok;
		r.average  = cur_avg;
		r.fill     = CNT_W'(win_fill);
		return r;
	endfunction

	// mostly near the average, some just past the drift bound, some anywhere
	function automatic sample_t pick_sample();
		longint      d;
		longint      off;
		longint      v;
		int unsigned r;
		d = longint'(drift_lim);
		r = $urandom_range(9);
		if (r == 9)
			return sample_t'($urandom);
		if (r == 8)
			off = $urandom_range(1) ? d + 1 : -d - 1;
		else
			off = longint'($urandom_range(32'(2 * d))) - d;
		v = longint'(cur_avg) + off;
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return sample_t'(v);
	endfunction

	task automatic send_sample(input sample_t smp);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic add_expected(input avg_result_t r);
		expected_averages = {expected_averages, r};
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_averages.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_max_drift(input drift_t v);
		wait_drained();
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		drift_lim = v;
		n_settings++;
	endtask

	initial begin
		avg_result_t r;
		sample_t     smp;
		drift_t      d;
		int          gap_tab   [4];
		int          stall_tab [4];

		gap_tab   = '{0, 50, 0, 21};
		stall_tab = '{0, 0, 50, 21};
		dir_rows = '{
			'{0, 32'sd100,          0, 1, 1, 32'sd100,  1},
			'{0, 32'h7FFF_FFFF,     0, 1, 0, 32'sd100,  1},
			'{0, 32'h8000_0000,     0, 1, 0, 32'sd100,  1},
			'{0, 32'sd10100,        0, 1, 1, 32'sd5100, 2},
			'{0, -32'sd4900,        0, 1, 1, 32'sd1767, 3},
			'{0, 32'sd11768,        0, 1, 0, 32'sd1767, 3},
			'{0, -32'sd8234,        0, 1, 0, 32'sd1767, 3},
			'{1, 0, 31'd0,             0, 0, 0, 0},
			'{0, 32'sd1767,         0, 1, 1, 32'sd1767, 4},
			'{0, 32'sd1768,         0, 1, 0, 32'sd1767, 4},
			'{0, 32'sd1766,         0, 1, 0, 32'sd1767, 4},
			'{1, 0, 31'h7FFF_FFFF,     0, 0, 0, 0},
			'{0, 32'h8000_0000,     0, 1, 0, 32'sd1767, 4},
			'{0, 32'h7FFF_FFFF,     0, 0, 0, 0, 0},
			'{0, 32'h7FFF_FFFF,     0, 0, 0, 0, 0},
			'{0, 32'h8000_0000,     0, 0, 0, 0, 0},
			'{0, 32'h8000_0000,     0, 0, 0, 0, 0},
			'{0, 32'h8000_0000,     0, 0, 0, 0, 0},
			'{0, 32'sd0,            0, 0, 0, 0, 0},
			'{0, -32'sd1,           0, 0, 0, 0, 0},
			'{0, 32'sd1,            0, 0, 0, 0, 0},
			'{0, 32'h5555_5555,     0, 0, 0, 0, 0},
			'{0, 32'hAAAA_AAAA,     0, 0, 0, 0, 0}
		};

		foreach (win_mem[i]) win_mem[i] = '0;
		win_fill   = 0;
		win_ptr    = 0;
		win_sum    = 0;
		cur_avg    = '0;
		is_locked  = 1'b0;
		drift_lim  = MAX_DRIFT_RST;
		avg_lo     = 32'h7FFF_FFFF;
		avg_hi     = 32'h8000_0000;
		gap_pct    = 21;
		stall_pct  = 21;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_max_drift(dir_rows[i].drift);
			end else begin
				send_sample(dir_rows[i].smp);
				r = update_window_average(dir_rows[i].smp);
				if (dir_rows[i].known)
					r = '{dir_rows[i].acc, dir_rows[i].avg, CNT_W'(dir_rows[i].cnt)};
				add_expected(r);
			end
		end

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: d = drift_t'($urandom_range(1000));
				1: d = 31'h7FFF_FFFF;
				2: d = '0;
				3: d = drift_t'($urandom_range(32'h7FFF_FFFF));
				4: d = MAX_DRIFT_RST;
				5: d = drift_t'($urandom_range(100));
				6: d = 31'h7FFF_FFFF;
				default: d = drift_t'($urandom_range(65535));
			endcase
			write_max_drift(d);
			gap_pct   = gap_tab[p % 4];
			stall_pct = stall_tab[p % 4];
			if (p == 0 || p == 4)
				hold_reqs <= hold_reqs + 1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				smp = pick_sample();
				send_sample(smp);
				add_expected(update_window_average(smp));
			end
		end

		wait_drained();
		repeat (60) @(posedge clk);

		$display("%0d samples: %0d accepted, %0d rejected, %0d evictions, %0d drift settings",
			n_acc + n_rej, n_acc, n_rej, n_wrap, n_settings);
		$display("averages seen from %0d to %0d", avg_lo, avg_hi);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/dgma_pkg.sv
rtl/dgma_ram.sv
rtl/dgma_div.sv
rtl/drift_gated_moving_average_top.sv
verif/drift_gated_moving_average_top_tb.sv
